### hw/rtl/base_pair_stem_score_assert.svh
// assertion macros used by the rtl top, compiled out for synthesis
`ifndef BASE_PAIR_STEM_SCORE_ASSERT_SVH
`define BASE_PAIR_STEM_SCORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpss assertion failed");
// next-cycle implication
`define BPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpss assertion failed");
`else
`define BPSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bpss_pkg.sv
`default_nettype none

package bpss_pkg;

	localparam int POS_W    = 10;
	localparam int BASE_W   = 3;
	localparam int LEN_W    = 11;
	localparam int SCORE_W  = 19;
	localparam int WEIGHT_W = 18;
	localparam int GAUSS_W  = 16;
	localparam int PROD_W   = WEIGHT_W + GAUSS_W;
	localparam int ACC_W    = SCORE_W + 1;
	// walk position: sign bit plus room for reach past the last base
	localparam int PW       = 12;
	localparam int FRAC_W   = 16;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// register index decoded from the address
	localparam logic CFG_SEQ_LENGTH = 1'b0;

	localparam logic [BASE_W-1:0] BASE_A = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T = 3'd3;

	localparam logic [WEIGHT_W-1:0] W_AT = 18'd131072;
	localparam logic [WEIGHT_W-1:0] W_GC = 18'd196608;
	localparam logic [WEIGHT_W-1:0] W_GT = 18'd52429;

	localparam logic [PROD_W:0]    ROUND_HALF = 35'd32768;
	localparam logic [SCORE_W-1:0] SCORE_MAX  = '1;

	typedef struct packed {
		logic              req_type;
		logic [POS_W-1:0]  pos_i;
		logic [POS_W-1:0]  pos_j;
		logic [BASE_W-1:0] base;
	} req_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               out_of_range;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CENTER,
		S_ADDR,
		S_WEIGHT,
		S_ACC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic ld_query;
		logic ld_base;
		logic rd_center;
		logic ld_center;
		logic init_dir1;
		logic ld_term;
		logic acc;
		logic dir;
	} dp_cmd_t;

	typedef struct packed {
		logic oor_in;
		logic step_ok;
		logic w_zero;
	} dp_sts_t;

	function automatic logic [WEIGHT_W-1:0] pair_weight(input logic [BASE_W-1:0] x,
		input logic [BASE_W-1:0] y);
		logic [WEIGHT_W-1:0] w;
		w = '0;
		if ((x == BASE_A && y == BASE_T) || (x == BASE_T && y == BASE_A))
			w = W_AT;
		else if ((x == BASE_G && y == BASE_C) || (x == BASE_C && y == BASE_G))
			w = W_GC;
		else if ((x == BASE_G && y == BASE_T) || (x == BASE_T && y == BASE_G))
			w = W_GT;
		return w;
	endfunction

	// exp(-a*a/2) with 16 fraction bits, only called for a >= 1
	function automatic logic [GAUSS_W-1:0] gauss(input logic [4:0] a);
		logic [GAUSS_W-1:0] g;
		case (a)
			5'd1:    g = 16'd39750;
			5'd2:    g = 16'd8869;
			5'd3:    g = 16'd728;
			5'd4:    g = 16'd22;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/base_pair_stem_score.sv
// base_pair_stem_score: a load transaction (req_type 0) writes one base code into the
// MAX_LEN-entry base store and finishes in its accepting cycle, so busy never rises and
// no result follows. A query transaction (req_type 1) scores the pair (pos_i, pos_j): the
// centre pair weight plus Gaussian weighted pair weights walking outward along the
// anti-diagonal on both sides, up to MAX_REACH steps each. busy rises after the accepting
// edge and stays high until the result; done is high for exactly one cycle with the
// result, and the receiver cannot stall it, so it must take the result in that cycle.
// After the accepting edge an out-of-range query gives its result in the next cycle, a
// zero centre pair passes S_CENTER then S_OUT, and a full walk ends after at most
// MAX_REACH steps per side. Each walk step on the single two-read base store passes
// S_ADDR (read both bases), S_WEIGHT (weight and rounded multiply) and S_ACC (accumulate).
// seq_length is written over the APB port at byte address 0 and should only change
// while busy is low. Store entries are not cleared at reset: load every base that a
// query can reach before querying it.
`default_nettype none
`include "base_pair_stem_score_assert.svh"

module base_pair_stem_score #(
	parameter int MAX_LEN   = 1024,
	parameter int MAX_REACH = 5
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// command channel
	input  wire logic           start,
	output logic                busy,
	input  wire bpss_pkg::req_t item,
	// result channel
	output logic                done,
	output bpss_pkg::res_t      result,
	// apb configuration port
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready
);

	logic [bpss_pkg::LEN_W-1:0] seq_length_q;
	logic                       cfg_wr;
	bpss_pkg::dp_cmd_t          cmd;
	bpss_pkg::dp_sts_t          sts;

	// apb: zero wait states, paddr[2] picks the register word
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == bpss_pkg::CFG_SEQ_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= bpss_pkg::LEN_W'(1);
		end else if (cfg_wr) begin
			seq_length_q <= pwdata[bpss_pkg::LEN_W-1:0];
		end
	end

	// unmapped word reads back as zero
	assign prdata = (paddr[2] == bpss_pkg::CFG_SEQ_LENGTH) ?
		32'(seq_length_q) : '0;

	// sequencer: accept, centre lookup, two outward walks, result
	bpss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(item.req_type),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// base store, pair weights, walk positions, multiplier and accumulator
	bpss_dp #(
		.MAX_LEN  (MAX_LEN),
		.MAX_REACH(MAX_REACH)
	) u_dp (
		.clk       (clk),
		.item      (item),
		.seq_length(seq_length_q),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	// an accepted query raises busy in the next cycle
	`BPSS_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && item.req_type == bpss_pkg::REQ_QUERY, busy)
	// a load finishes at once and never makes a result
	`BPSS_ASSERT_NEXT(a_load_silent, clk, arst_n, start && !busy && item.req_type == bpss_pkg::REQ_LOAD, !busy && !done)
	// the result closes the transaction
	`BPSS_ASSERT_NEXT(a_done_frees, clk, arst_n, done, !busy)
	// results only come inside a query transaction
	`BPSS_ASSERT_IMPL(a_done_in_query, clk, arst_n, done, busy)
	// out-of-range queries report a zero score
	`BPSS_ASSERT_IMPL(a_oor_zero, clk, arst_n, done && result.out_of_range, result.score == '0)

endmodule

`default_nettype wire

### hw/rtl/bpss_ram.sv
`default_nettype none

module bpss_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### hw/rtl/bpss_ctrl.sv
`default_nettype none

module bpss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              req_type,
	input  wire bpss_pkg::dp_sts_t sts,
	output bpss_pkg::dp_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	bpss_pkg::state_t state_q, state_d;
	logic             dir_q, dir_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpss_pkg::S_IDLE;
			dir_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.dir = dir_q;
		state_d = state_q;
		dir_d   = dir_q;
		busy    = (state_q != bpss_pkg::S_IDLE);
		done    = (state_q == bpss_pkg::S_OUT);
		unique case (state_q)
			bpss_pkg::S_IDLE: begin
				if (start) begin
					if (req_type == bpss_pkg::REQ_QUERY) begin
						cmd.ld_query  = 1'b1;
						cmd.rd_center = 1'b1;
						state_d = sts.oor_in ? bpss_pkg::S_OUT : bpss_pkg::S_CENTER;
					end else begin
						cmd.ld_base = 1'b1;
					end
				end
			end
			bpss_pkg::S_CENTER: begin
				cmd.ld_center = 1'b1;
				dir_d = 1'b0;
				state_d = sts.w_zero ? bpss_pkg::S_OUT : bpss_pkg::S_ADDR;
			end
			bpss_pkg::S_ADDR: begin
				if (sts.step_ok) begin
					state_d = bpss_pkg::S_WEIGHT;
				end else if (!dir_q) begin
					cmd.init_dir1 = 1'b1;
					dir_d = 1'b1;
				end else begin
					state_d = bpss_pkg::S_OUT;
				end
			end
			bpss_pkg::S_WEIGHT: begin
				if (!sts.w_zero) begin
					cmd.ld_term = 1'b1;
					state_d = bpss_pkg::S_ACC;
				end else if (!dir_q) begin
					cmd.init_dir1 = 1'b1;
					dir_d = 1'b1;
					state_d = bpss_pkg::S_ADDR;
				end else begin
					state_d = bpss_pkg::S_OUT;
				end
			end
			bpss_pkg::S_ACC: begin
				cmd.acc = 1'b1;
				state_d = bpss_pkg::S_ADDR;
			end
			bpss_pkg::S_OUT: begin
				state_d = bpss_pkg::S_IDLE;
			end
			default: begin
				state_d = bpss_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/bpss_dp.sv
`default_nettype none

module bpss_dp #(
	parameter int MAX_LEN   = 1024,
	parameter int MAX_REACH = 5
) (
	input  wire logic                                clk,
	input  wire bpss_pkg::req_t                      item,
	input  wire logic [bpss_pkg::LEN_W-1:0]          seq_length,
	input  wire bpss_pkg::dp_cmd_t                   cmd,
	output bpss_pkg::dp_sts_t                        sts,
	output bpss_pkg::res_t                           result
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int SW = $clog2(MAX_REACH + 2);
	localparam int PW = bpss_pkg::PW;

	logic [bpss_pkg::POS_W-1:0]    pi_q, pj_q;
	logic [PW-1:0]                 p_q, q_q;
	logic [SW-1:0]                 step_q;
	logic [bpss_pkg::ACC_W-1:0]    sum_q;
	logic [bpss_pkg::SCORE_W-1:0]  term_q;
	logic                          oor_q;

	logic [bpss_pkg::LEN_W-1:0]    n_eff;
	logic [AW-1:0]                 raddr_a, raddr_b;
	logic [bpss_pkg::BASE_W-1:0]   rdata_a, rdata_b;
	logic [bpss_pkg::WEIGHT_W-1:0] w_cur;
	logic [bpss_pkg::GAUSS_W-1:0]  g_cur;
	logic [bpss_pkg::PROD_W-1:0]   prod;
	logic [bpss_pkg::PROD_W:0]     prod_rnd;
	logic                          p_ok, q_ok, we;

	// effective length is the register clipped to the store depth
	assign n_eff = (17'(seq_length) > 17'(MAX_LEN)) ? bpss_pkg::LEN_W'(MAX_LEN) : seq_length;

	assign we = cmd.ld_base && (17'(item.pos_i) < 17'(MAX_LEN));

	assign raddr_a = cmd.rd_center ? AW'(item.pos_i) : AW'(p_q);
	assign raddr_b = cmd.rd_center ? AW'(item.pos_j) : AW'(q_q);

	bpss_ram #(
		.WIDTH(bpss_pkg::BASE_W),
		.DEPTH(MAX_LEN)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (AW'(item.pos_i)),
		.wdata  (item.base),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign w_cur    = bpss_pkg::pair_weight(rdata_a, rdata_b);
	assign g_cur    = bpss_pkg::gauss(5'(step_q));
	assign prod     = w_cur * g_cur;
	assign prod_rnd = {1'b0, prod} + bpss_pkg::ROUND_HALF;

	assign p_ok = !p_q[PW-1] && (p_q[PW-2:0] < n_eff);
	assign q_ok = !q_q[PW-1] && (q_q[PW-2:0] < n_eff);

	assign sts.oor_in  = ({1'b0, item.pos_i} >= n_eff) || ({1'b0, item.pos_j} >= n_eff);
	assign sts.step_ok = p_ok && q_ok && (step_q <= SW'(MAX_REACH));
	assign sts.w_zero  = (w_cur == '0);

	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			pi_q  <= item.pos_i;
			pj_q  <= item.pos_j;
			oor_q <= sts.oor_in;
			sum_q <= '0;
		end
		if (cmd.ld_center) begin
			sum_q  <= bpss_pkg::ACC_W'(w_cur);
			p_q    <= {2'b00, pi_q} - PW'(1);
			q_q    <= {2'b00, pj_q} + PW'(1);
			step_q <= SW'(1);
		end
		if (cmd.init_dir1) begin
			p_q    <= {2'b00, pi_q} + PW'(1);
			q_q    <= {2'b00, pj_q} - PW'(1);
			step_q <= SW'(1);
		end
		if (cmd.ld_term) begin
			term_q <= prod_rnd[bpss_pkg::PROD_W:bpss_pkg::FRAC_W];
		end
		if (cmd.acc) begin
			sum_q  <= sum_q + bpss_pkg::ACC_W'(term_q);
			p_q    <= cmd.dir ? p_q + PW'(1) : p_q - PW'(1);
			q_q    <= cmd.dir ? q_q - PW'(1) : q_q + PW'(1);
			step_q <= step_q + SW'(1);
		end
	end

	assign result.score = (sum_q > bpss_pkg::ACC_W'(bpss_pkg::SCORE_MAX)) ?
		bpss_pkg::SCORE_MAX : sum_q[bpss_pkg::SCORE_W-1:0];
	assign result.out_of_range = oor_q;

endmodule

`default_nettype wire
